### rtl/register_rename_unit_assert.svh
// Assertion macros used by the rename unit checker.
`ifndef REGISTER_RENAME_UNIT_ASSERT_SVH
`define REGISTER_RENAME_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("register_rename_unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RRU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("register_rename_unit: next-cycle check failed");

`endif

### rtl/rru_pkg.sv
// Shared types and constants of the register rename unit.
`default_nettype none

package rru_pkg;

    localparam int PHYS_REGS_DEF = 32;
    localparam int ARCH_REGS_DEF = 64;

    // Command codes; the spare code is ignored by the unit.
    localparam logic [1:0] CMD_RENAME  = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_SQUASH  = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    // Source operand kinds; the spare kind behaves as an ordinary register.
    localparam logic [1:0] KIND_ORD   = 2'd0;
    localparam logic [1:0] KIND_ZERO  = 2'd1;
    localparam logic [1:0] KIND_PC    = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Source classes reported with a result.
    localparam logic [1:0] CLS_MAPPED = 2'd0;
    localparam logic [1:0] CLS_NONE   = 2'd1;
    localparam logic [1:0] CLS_ZERO   = 2'd2;
    localparam logic [1:0] CLS_PC     = 2'd3;

    // Control from the sequencer to the free list.
    typedef struct packed {
        logic rd;
        logic take;
        logic give;
        logic to_tail;
    } rru_fl_ctrl_t;

endpackage

`default_nettype wire

### rtl/rru_if.sv
// Request and result channel interfaces of the register rename unit.
`default_nettype none

interface rru_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        uses_first_source;
    logic        uses_second_source;
    logic        uses_destination;
    logic [5:0]  first_source_index;
    logic [1:0]  first_source_kind;
    logic [5:0]  second_source_index;
    logic [1:0]  second_source_kind;
    logic [5:0]  target_index;
    logic [31:0] pending_mask;
    logic        to_tail;

    modport source (
        output valid, command, uses_first_source, uses_second_source, uses_destination,
               first_source_index, first_source_kind, second_source_index,
               second_source_kind, target_index, pending_mask, to_tail,
        input  ready
    );
    modport sink (
        input  valid, command, uses_first_source, uses_second_source, uses_destination,
               first_source_index, first_source_kind, second_source_index,
               second_source_kind, target_index, pending_mask, to_tail,
        output ready
    );
endinterface

interface rru_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] first_source_class;
    logic [4:0] first_source_phys;
    logic [1:0] second_source_class;
    logic [4:0] second_source_phys;
    logic       destination_valid;
    logic [4:0] destination_phys;
    logic [4:0] freed_phys;

    modport source (
        output valid, accepted, first_source_class, first_source_phys,
               second_source_class, second_source_phys, destination_valid,
               destination_phys, freed_phys,
        input  ready
    );
    modport sink (
        input  valid, accepted, first_source_class, first_source_phys,
               second_source_class, second_source_phys, destination_valid,
               destination_phys, freed_phys,
        output ready
    );
endinterface

`default_nettype wire

### rtl/rru_free_list.sv
// Circular free list of physical registers held in a synchronous memory.
`default_nettype none

module rru_free_list #(
    parameter int PHYS_REGS = rru_pkg::PHYS_REGS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rru_pkg::rru_fl_ctrl_t              ctrl,
    input  logic [$clog2(PHYS_REGS)-1:0]       give_phys,
    output logic [$clog2(PHYS_REGS)-1:0]       head_phys,
    output logic [$clog2(PHYS_REGS+1)-1:0]     free_count
);

    localparam int PW = $clog2(PHYS_REGS);
    localparam int CW = $clog2(PHYS_REGS + 1);
    localparam int SW = PW + 2;

    logic [PW-1:0]        mem [PHYS_REGS];
    logic [PHYS_REGS-1:0] vld_reg;
    logic [PW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [PW-1:0]        rd_q_reg, ra_q_reg;
    logic                 rv_reg;

    logic [SW-1:0] tail_sum;
    logic [PW-1:0] tail_addr, head_dec, head_inc, waddr;
    logic          do_give;

    // Slot addresses, wrapped to the queue depth.
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(PHYS_REGS)) ? PW'(tail_sum - SW'(PHYS_REGS))
                                                    : PW'(tail_sum);
    assign head_dec  = (head_reg == '0) ? PW'(PHYS_REGS - 1) : head_reg - PW'(1);
    assign head_inc  = (head_reg == PW'(PHYS_REGS - 1)) ? '0 : head_reg + PW'(1);
    assign do_give   = ctrl.give && (count_reg < CW'(PHYS_REGS));
    assign waddr     = ctrl.to_tail ? tail_addr : head_dec;

    // A slot never written reads as its own index, through its valid bit.
    assign head_phys  = rv_reg ? rd_q_reg : ra_q_reg;
    assign free_count = count_reg;

    // Head and count update.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.take)
        begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end
        else if (do_give)
        begin
            if (!ctrl.to_tail)
            begin
                head_next = head_dec;
            end
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= CW'(PHYS_REGS);
            vld_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (do_give)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (ctrl.rd)
            begin
                rv_reg <= vld_reg[head_reg];
            end
        end
    end

    // Memory write and registered read of the head slot.
    always_ff @(posedge clk)
    begin
        if (do_give)
        begin
            mem[waddr] <= give_phys;
        end
        if (ctrl.rd)
        begin
            rd_q_reg <= mem[head_reg];
            ra_q_reg <= head_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/register_rename_unit.sv
// Register rename unit: map table, mapping chains and free list sequencer.
//
// Requests arrive on req (valid/ready) and each produces exactly one result
// on rsp (valid/ready). One request is worked on at a time; req.ready is high
// only while the sequencer is idle, and a finished result sits in an output
// register so the next request is taken while that result waits.
// Every step of the sequencer does at most one read of the map table memory
// and one of the link memory, each with its data registered for the next
// step. A rename looks up both sources, checks that enough registers are
// free, then allocates one register at a time for each ordinary source in
// use with no mapping and for a destination in use, or is refused for lack
// of free registers; a release of the oldest mapping walks the chain from
// the newest mapping one link read at a time, and does nothing with only one
// mapping or none; a squash pops the newest mapping, and does nothing with
// no mapping; other commands go straight to the result.
// Reset empties every map table entry and refills the free list with all
// physical registers in order, at once, through valid bits; no clearing pass.
// If rsp is stalled, a finished result holds in the sequencer until the
// output register is taken, and no new request is accepted in the meantime.
`default_nettype none

module register_rename_unit #(
    parameter int PHYS_REGS = rru_pkg::PHYS_REGS_DEF,
    parameter int ARCH_REGS = rru_pkg::ARCH_REGS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rru_req_if.sink   req,
    rru_rsp_if.source rsp
);

    import rru_pkg::*;

    localparam int PW = $clog2(PHYS_REGS);
    localparam int AW = $clog2(ARCH_REGS);
    localparam int CW = $clog2(PHYS_REGS + 1);
    localparam int EW = PW + 5;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_RD0  = 13'b0000000000010,
        S_RD1  = 13'b0000000000100,
        S_CHK  = 13'b0000000001000,
        S_ARD  = 13'b0000000010000,
        S_AWR  = 13'b0000000100000,
        S_REL  = 13'b0000001000000,
        S_WALK = 13'b0000010000000,
        S_WLD  = 13'b0000100000000,
        S_FREE = 13'b0001000000000,
        S_SQ   = 13'b0010000000000,
        S_SQ2  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    // Arch index wrapped to the table depth by repeated subtraction.
    function automatic logic [AW-1:0] wrap_arch(input logic [5:0] v);
        logic [6:0] t;
        t = {1'b0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 7'(ARCH_REGS))
            begin
                t = t - 7'(ARCH_REGS);
            end
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [4:0] to5(input logic [PW-1:0] x);
        logic [EW-1:0] w;
        w = {5'b0, x};
        return w[4:0];
    endfunction

    // Registers above 31 have no pending bit and read as not pending.
    function automatic logic pend_at(input logic [31:0] m, input logic [PW-1:0] c);
        logic [EW-1:0] w;
        w = {5'b0, c};
        return (w < EW'(32)) ? m[w[4:0]] : 1'b0;
    endfunction

    state_t state_reg, state_next;

    // Latched request.
    logic [1:0]    cmd_reg, cmd_next;
    logic          use0_reg, use0_next, use1_reg, use1_next, used_reg, used_next;
    logic [AW-1:0] s0_reg, s0_next, s1_reg, s1_next, tgt_reg, tgt_next;
    logic [1:0]    kind0_reg, kind0_next, kind1_reg, kind1_next;
    logic [31:0]   pend_reg, pend_next;
    logic          tail_reg, tail_next;

    // Working values.
    logic          map0_zero_reg, map0_zero_next;
    logic [PW-1:0] map0_phys_reg, map0_phys_next;
    logic [2:0]    todo_reg, todo_next;
    logic [PW-1:0] cur_reg, cur_next, top_reg, top_next;
    logic [CW-1:0] left_reg, left_next, n_reg, n_next;
    logic          npend_reg, npend_next;

    // Result under construction.
    logic          r_acc_reg, r_acc_next, r_dv_reg, r_dv_next;
    logic [1:0]    r_cls0_reg, r_cls0_next, r_cls1_reg, r_cls1_next;
    logic [PW-1:0] r_ph0_reg, r_ph0_next, r_ph1_reg, r_ph1_next;
    logic [PW-1:0] r_dp_reg, r_dp_next, r_freed_reg, r_freed_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic       out_acc_reg, out_dv_reg;
    logic [1:0] out_cls0_reg, out_cls1_reg;
    logic [4:0] out_ph0_reg, out_ph1_reg, out_dp_reg, out_freed_reg;
    logic       out_load;

    // Map table memory: count and newest mapping per arch register.
    logic [CW+PW-1:0]     arch_mem [ARCH_REGS];
    logic [ARCH_REGS-1:0] arch_vld_reg;
    logic [AW-1:0]        arch_raddr, arch_waddr;
    logic                 arch_we;
    logic [CW+PW-1:0]     arch_wdata, arch_q_reg;
    logic                 arch_rv_reg;
    logic [CW-1:0]        arch_cnt;
    logic [PW-1:0]        arch_phys;

    // Link memory: next older mapping after each physical register.
    logic [PW-1:0] link_mem [PHYS_REGS];
    logic [PW-1:0] link_raddr, link_waddr, link_wdata, link_q_reg;
    logic          link_we;

    // Free list.
    rru_fl_ctrl_t  fl_ctrl;
    logic [PW-1:0] fl_give_phys, fl_head_phys;
    logic [CW-1:0] fl_count;

    // Helpers.
    logic          accept, ord0, ord1, alloc0, alloc1;
    logic [1:0]    need;
    logic [AW-1:0] slot_addr;
    logic [CW-1:0] dec_cnt;

    rru_free_list #(
        .PHYS_REGS (PHYS_REGS)
    ) u_free_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fl_ctrl),
        .give_phys  (fl_give_phys),
        .head_phys  (fl_head_phys),
        .free_count (fl_count)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign arch_cnt  = arch_rv_reg ? arch_q_reg[CW+PW-1:PW] : '0;
    assign arch_phys = arch_q_reg[PW-1:0];

    assign ord0   = (kind0_reg != KIND_ZERO) && (kind0_reg != KIND_PC);
    assign ord1   = (kind1_reg != KIND_ZERO) && (kind1_reg != KIND_PC);
    assign alloc0 = use0_reg && ord0 && map0_zero_reg;
    assign alloc1 = use1_reg && ord1 && (arch_cnt == '0);
    assign need   = 2'(used_reg) + 2'(alloc0) + 2'(alloc1);

    // The lowest pending allocation is served first: sources, then destination.
    assign slot_addr = todo_reg[0] ? s0_reg : (todo_reg[1] ? s1_reg : tgt_reg);
    assign dec_cnt   = n_reg - CW'(1);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        use0_next      = use0_reg;
        use1_next      = use1_reg;
        used_next      = used_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        tgt_next       = tgt_reg;
        kind0_next     = kind0_reg;
        kind1_next     = kind1_reg;
        pend_next      = pend_reg;
        tail_next      = tail_reg;
        map0_zero_next = map0_zero_reg;
        map0_phys_next = map0_phys_reg;
        todo_next      = todo_reg;
        cur_next       = cur_reg;
        top_next       = top_reg;
        left_next      = left_reg;
        n_next         = n_reg;
        npend_next     = npend_reg;
        r_acc_next     = r_acc_reg;
        r_dv_next      = r_dv_reg;
        r_cls0_next    = r_cls0_reg;
        r_cls1_next    = r_cls1_reg;
        r_ph0_next     = r_ph0_reg;
        r_ph1_next     = r_ph1_reg;
        r_dp_next      = r_dp_reg;
        r_freed_next   = r_freed_reg;
        arch_raddr     = tgt_reg;
        arch_we        = 1'b0;
        arch_waddr     = tgt_reg;
        arch_wdata     = {dec_cnt, top_reg};
        link_raddr     = cur_reg;
        link_we        = 1'b0;
        link_waddr     = fl_head_phys;
        link_wdata     = '0;
        fl_ctrl        = '0;
        fl_give_phys   = cur_reg;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = req.command;
                    use0_next    = req.uses_first_source;
                    use1_next    = req.uses_second_source;
                    used_next    = req.uses_destination;
                    s0_next      = wrap_arch(req.first_source_index);
                    s1_next      = wrap_arch(req.second_source_index);
                    tgt_next     = wrap_arch(req.target_index);
                    kind0_next   = req.first_source_kind;
                    kind1_next   = req.second_source_kind;
                    pend_next    = req.pending_mask;
                    tail_next    = req.to_tail;
                    r_acc_next   = 1'b0;
                    r_dv_next    = 1'b0;
                    r_cls0_next  = CLS_NONE;
                    r_cls1_next  = CLS_NONE;
                    r_ph0_next   = '0;
                    r_ph1_next   = '0;
                    r_dp_next    = '0;
                    r_freed_next = '0;
                    state_next   = S_RD0;
                end
            end

            S_RD0:
            begin
                arch_raddr = (cmd_reg == CMD_RENAME) ? s0_reg : tgt_reg;
                case (cmd_reg)
                    CMD_RENAME:  state_next = S_RD1;
                    CMD_RELEASE: state_next = S_REL;
                    CMD_SQUASH:  state_next = S_SQ;
                    default:     state_next = S_DONE;
                endcase
            end

            S_RD1:
            begin
                map0_zero_next = (arch_cnt == '0);
                map0_phys_next = arch_phys;
                arch_raddr     = s1_reg;
                state_next     = S_CHK;
            end

            // Both sources looked up before any allocation; check capacity.
            S_CHK:
            begin
                if (CW'(need) > fl_count)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    r_acc_next = 1'b1;
                    if (!use0_reg)
                        r_cls0_next = CLS_NONE;
                    else if (kind0_reg == KIND_ZERO)
                        r_cls0_next = CLS_ZERO;
                    else if (kind0_reg == KIND_PC)
                        r_cls0_next = CLS_PC;
                    else
                    begin
                        r_cls0_next = CLS_MAPPED;
                        r_ph0_next  = map0_zero_reg ? '0 : map0_phys_reg;
                    end
                    if (!use1_reg)
                        r_cls1_next = CLS_NONE;
                    else if (kind1_reg == KIND_ZERO)
                        r_cls1_next = CLS_ZERO;
                    else if (kind1_reg == KIND_PC)
                        r_cls1_next = CLS_PC;
                    else
                    begin
                        r_cls1_next = CLS_MAPPED;
                        r_ph1_next  = (arch_cnt == '0) ? '0 : arch_phys;
                    end
                    todo_next  = {used_reg, alloc1, alloc0};
                    state_next = S_ARD;
                end
            end

            S_ARD:
            begin
                if (todo_reg == 3'b000)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    arch_raddr = slot_addr;
                    fl_ctrl.rd = 1'b1;
                    state_next = S_AWR;
                end
            end

            // Push the free list head onto the chosen register's chain.
            S_AWR:
            begin
                fl_ctrl.take = 1'b1;
                link_we      = 1'b1;
                link_waddr   = fl_head_phys;
                link_wdata   = (arch_cnt != '0) ? arch_phys : '0;
                arch_we      = 1'b1;
                arch_waddr   = slot_addr;
                arch_wdata   = {arch_cnt + CW'(1), fl_head_phys};
                if (todo_reg[0])
                begin
                    r_ph0_next   = fl_head_phys;
                    todo_next[0] = 1'b0;
                end
                else if (todo_reg[1])
                begin
                    r_ph1_next   = fl_head_phys;
                    todo_next[1] = 1'b0;
                end
                else
                begin
                    r_dp_next    = fl_head_phys;
                    r_dv_next    = 1'b1;
                    todo_next[2] = 1'b0;
                end
                state_next = S_ARD;
            end

            S_REL:
            begin
                if (arch_cnt > CW'(1))
                begin
                    cur_next   = arch_phys;
                    top_next   = arch_phys;
                    n_next     = arch_cnt;
                    left_next  = arch_cnt - CW'(1);
                    npend_next = 1'b0;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Walk from the newest mapping toward the oldest.
            S_WALK:
            begin
                npend_next = npend_reg || !pend_at(pend_reg, cur_reg);
                link_raddr = cur_reg;
                left_next  = left_reg - CW'(1);
                state_next = S_WLD;
            end

            S_WLD:
            begin
                cur_next   = link_q_reg;
                state_next = (left_reg == '0) ? S_FREE : S_WALK;
            end

            S_FREE:
            begin
                if (npend_reg)
                begin
                    arch_we         = 1'b1;
                    arch_waddr      = tgt_reg;
                    arch_wdata      = {dec_cnt, top_reg};
                    fl_ctrl.give    = 1'b1;
                    fl_ctrl.to_tail = tail_reg;
                    fl_give_phys    = cur_reg;
                    r_freed_next    = cur_reg;
                    r_acc_next      = 1'b1;
                end
                state_next = S_DONE;
            end

            S_SQ:
            begin
                if (arch_cnt != '0)
                begin
                    top_next   = arch_phys;
                    n_next     = arch_cnt;
                    link_raddr = arch_phys;
                    state_next = S_SQ2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Pop the newest mapping; the next older one becomes newest.
            S_SQ2:
            begin
                arch_we         = 1'b1;
                arch_waddr      = tgt_reg;
                arch_wdata      = {dec_cnt, (dec_cnt != '0) ? link_q_reg : top_reg};
                fl_ctrl.give    = 1'b1;
                fl_ctrl.to_tail = tail_reg;
                fl_give_phys    = top_reg;
                r_freed_next    = top_reg;
                r_acc_next      = 1'b1;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            arch_vld_reg  <= '0;
            arch_rv_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            arch_rv_reg   <= arch_vld_reg[arch_raddr];
            if (arch_we)
            begin
                arch_vld_reg[arch_waddr] <= 1'b1;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        use0_reg      <= use0_next;
        use1_reg      <= use1_next;
        used_reg      <= used_next;
        s0_reg        <= s0_next;
        s1_reg        <= s1_next;
        tgt_reg       <= tgt_next;
        kind0_reg     <= kind0_next;
        kind1_reg     <= kind1_next;
        pend_reg      <= pend_next;
        tail_reg      <= tail_next;
        map0_zero_reg <= map0_zero_next;
        map0_phys_reg <= map0_phys_next;
        todo_reg      <= todo_next;
        cur_reg       <= cur_next;
        top_reg       <= top_next;
        left_reg      <= left_next;
        n_reg         <= n_next;
        npend_reg     <= npend_next;
        r_acc_reg     <= r_acc_next;
        r_dv_reg      <= r_dv_next;
        r_cls0_reg    <= r_cls0_next;
        r_cls1_reg    <= r_cls1_next;
        r_ph0_reg     <= r_ph0_next;
        r_ph1_reg     <= r_ph1_next;
        r_dp_reg      <= r_dp_next;
        r_freed_reg   <= r_freed_next;
        if (out_load)
        begin
            out_acc_reg   <= r_acc_reg;
            out_dv_reg    <= r_dv_reg;
            out_cls0_reg  <= r_cls0_reg;
            out_cls1_reg  <= r_cls1_reg;
            out_ph0_reg   <= to5(r_ph0_reg);
            out_ph1_reg   <= to5(r_ph1_reg);
            out_dp_reg    <= to5(r_dp_reg);
            out_freed_reg <= to5(r_freed_reg);
        end
    end

    // Map table and link memories: one write, one registered read each.
    always_ff @(posedge clk)
    begin
        if (arch_we)
        begin
            arch_mem[arch_waddr] <= arch_wdata;
        end
        arch_q_reg <= arch_mem[arch_raddr];
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q_reg <= link_mem[link_raddr];
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.accepted            = out_acc_reg;
    assign rsp.first_source_class  = out_cls0_reg;
    assign rsp.first_source_phys   = out_ph0_reg;
    assign rsp.second_source_class = out_cls1_reg;
    assign rsp.second_source_phys  = out_ph1_reg;
    assign rsp.destination_valid   = out_dv_reg;
    assign rsp.destination_phys    = out_dp_reg;
    assign rsp.freed_phys          = out_freed_reg;

endmodule

`default_nettype wire

### rtl/rru_checker.sv
// Port-level checks of the register rename unit, bound to the top level.
`default_nettype none

`include "register_rename_unit_assert.svh"

module rru_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       accepted,
    input logic [1:0] cls0,
    input logic [1:0] cls1,
    input logic       dest_valid,
    input logic [4:0] dest_phys,
    input logic [4:0] freed
);

    import rru_pkg::*;

    // One request at a time: the unit is busy right after taking one.
    `RRU_ASSERT_NEXT(busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)

    // A refused or ignored request reports no sources, no allocation, no free.
    `RRU_ASSERT_NOW(refused_is_empty, clk, rst_n, out_valid && !accepted, (cls0 == CLS_NONE) && (cls1 == CLS_NONE) && !dest_valid && (freed == 5'd0))

    // A destination is only allocated by an accepted rename, which frees nothing.
    `RRU_ASSERT_NOW(dest_needs_accept, clk, rst_n, out_valid && dest_valid, accepted && (freed == 5'd0))

    // A stalled result holds.
    `RRU_ASSERT_NEXT(result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(dest_phys) && $stable(freed))

endmodule

bind register_rename_unit rru_checker u_rru_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .accepted   (rsp.accepted),
    .cls0       (rsp.first_source_class),
    .cls1       (rsp.second_source_class),
    .dest_valid (rsp.destination_valid),
    .dest_phys  (rsp.destination_phys),
    .freed      (rsp.freed_phys)
);

`default_nettype wire
